// File: design/pts_pkg.sv
// Package for the priority task scheduler: sizes, action codes and cell types.
// No dependencies.
package pts_pkg;
   localparam int MaxTasks = 8;
   localparam int IdxW = $clog2(MaxTasks);
   localparam int CntW = $clog2(MaxTasks + 1);
   localparam logic [7:0] PrioReserved = 8'd255;

   typedef enum logic [2:0] {
      ACT_TICK = 3'd0, ACT_SCHED = 3'd1, ACT_CREATE = 3'd2, ACT_SLEEP = 3'd3,
      ACT_SUSPEND = 3'd4, ACT_RESUME = 3'd5, ACT_SETPRIO = 3'd6, ACT_NONE = 3'd7
   } action_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic             wake;      // run the sleeper wake check
      logic             create;    // initialize the cell at wr_idx
      logic             sleep;     // put the cell at wr_idx to sleep
      logic             suspend;
      logic             resume;
      logic             setprio;
      logic [IdxW-1:0]  wr_idx;
      logic [7:0]       prio;
      logic [31:0]      duration;
      logic [31:0]      tick;
   } cell_cmd_type;

   // Status one cell reports back.
   typedef struct packed {
      logic       suspended;
      logic       ready;       // neither suspended nor blocked
      logic [7:0] prio;
   } cell_stat_type;

   // Search token passed from cell to cell along the ring.
   typedef struct packed {
      logic [8:0]      best;   // 256 means none found
      logic [IdxW-1:0] pick;
   } token_type;
endpackage

// File: design/priority_task_scheduler.sv
// Top level of the priority task scheduler: controller, slot cells and scan.
// Depends on pts_pkg, pts_cell and pts_scan.
//
// Usage: one request transaction carries an action (tick, schedule, create,
// sleep, suspend, resume, set priority) and its operands; exactly one
// response transaction (ok, task_index) follows for each request.
// A tick, create, suspend, resume or set priority answers straight from the
// execute state. Schedule and sleep, when a task exists (and, for sleep, after
// launch), run the wake check in the cells (the launching schedule skips it),
// then walk a search token around the ring of slots one slot per cycle.
// One request is in work at a time; req_ready is high while no request is in
// work and the response register is empty or being emptied.
// Reset clears all flags, the task count, the current task, the launch flag
// and the tick counter. When the receiver stalls the response holds in its
// register and no new request is taken until it is delivered.
module priority_task_scheduler (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pts_pkg::action_type    req_action,
   input  logic [2:0]             req_task_id,
   input  logic [7:0]             req_prio_value,
   input  logic [31:0]            req_duration,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_ok,
   output logic [2:0]             rsp_task_index
);
   import pts_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAKE, ST_SCAN} state_type;

   state_type          state_ff;
   action_type         act_ff;
   logic [2:0]         tid_ff;
   logic [7:0]         prio_ff;
   logic [31:0]        dur_ff;
   logic [CntW-1:0]    count_ff;
   logic [IdxW-1:0]    cur_ff;
   logic               launched_ff;
   logic [31:0]        tick_ff;
   logic [CntW-1:0]    step_ff;
   logic [IdxW-1:0]    pos_ff;
   logic               launch_ff;
   token_type          tok_ff, tok_in;
   logic               rsp_valid_ff, rsp_ok_ff;
   logic [2:0]         rsp_idx_ff;

   cell_cmd_type       cmd;
   cell_stat_type      stats [MaxTasks];
   cell_stat_type      stat_sel;
   logic               accept, tid_ok, exec;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign tid_ok = ({1'b0, tid_ff} < {{(CntW > 4 ? CntW - 4 : 0){1'b0}}, count_ff});
   assign stat_sel = stats[tid_ff[IdxW-1:0]];
   assign exec = (state_ff == ST_EXEC);

   // Commands to the row of cells.
   always_comb begin
      cmd = '0;
      cmd.tick = tick_ff;
      cmd.prio = prio_ff;
      cmd.duration = dur_ff;
      cmd.wr_idx = tid_ff[IdxW-1:0];
      cmd.wake = (state_ff == ST_WAKE);
      if (exec) begin
         unique case (act_ff)
            ACT_CREATE: begin
               cmd.wr_idx = count_ff[IdxW-1:0];
               cmd.create = (count_ff < CntW'(MaxTasks)) &&
                            !(prio_ff == PrioReserved && count_ff != '0);
            end
            ACT_SLEEP: begin
               cmd.wr_idx = cur_ff;
               cmd.sleep = launched_ff && count_ff != '0 && dur_ff != '0;
            end
            ACT_SUSPEND: cmd.suspend = tid_ok && !stat_sel.suspended;
            ACT_RESUME:  cmd.resume = tid_ok && stat_sel.suspended;
            ACT_SETPRIO: cmd.setprio = tid_ok;
            default: ;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < MaxTasks; g++) begin : g_cell
         pts_cell u_cell (
            .clock(clock), .reset(reset), .cell_idx(IdxW'(g)),
            .cmd(cmd), .stat(stats[g])
         );
      end
   endgenerate

   // The token moves one slot per cycle through a shared compare stage.
   pts_scan u_scan (
      .launch(launch_ff), .active(1'b1), .idx(pos_ff),
      .stat(stats[pos_ff]), .tok_in(tok_ff), .tok_out(tok_in)
   );

   // Controller and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         launched_ff  <= 1'b0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  act_ff  <= req_action;
                  tid_ff  <= req_task_id;
                  prio_ff <= req_prio_value;
                  dur_ff  <= req_duration;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_ok_ff  <= 1'b0;
               rsp_idx_ff <= 3'(cur_ff);
               tok_ff.best <= 9'd256;
               tok_ff.pick <= cur_ff;
               step_ff <= '0;
               launch_ff <= 1'b0;
               pos_ff <= (cur_ff == IdxW'(count_ff - 1'b1)) ? '0 : cur_ff + 1'b1;
               state_ff <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               unique case (act_ff)
                  ACT_TICK: begin
                     tick_ff <= tick_ff + 1'b1;
                     rsp_ok_ff <= 1'b1;
                  end
                  ACT_SCHED: begin
                     if (count_ff != '0) begin
                        rsp_valid_ff <= 1'b0;
                        if (!launched_ff) begin
                           launch_ff <= 1'b1;
                           pos_ff <= '0;
                           tok_ff.best <= {1'b0, stats[0].prio};
                           tok_ff.pick <= '0;
                           state_ff <= ST_SCAN;
                        end else begin
                           state_ff <= ST_WAKE;
                        end
                     end
                  end
                  ACT_CREATE: begin
                     rsp_idx_ff <= '0;
                     if (cmd.create) begin
                        rsp_ok_ff <= 1'b1;
                        rsp_idx_ff <= 3'(count_ff);
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  ACT_SLEEP: begin
                     if (launched_ff && count_ff != '0) begin
                        rsp_valid_ff <= 1'b0;
                        state_ff <= ST_WAKE;
                     end
                  end
                  ACT_SUSPEND: rsp_ok_ff <= cmd.suspend;
                  ACT_RESUME:  rsp_ok_ff <= cmd.resume;
                  ACT_SETPRIO: rsp_ok_ff <= cmd.setprio;
                  default: ;
               endcase
            end
            ST_WAKE: state_ff <= ST_SCAN;
            ST_SCAN: begin
               tok_ff <= tok_in;
               pos_ff <= (pos_ff == IdxW'(count_ff - 1'b1)) ? '0 : pos_ff + 1'b1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == count_ff - 1'b1) begin
                  cur_ff <= tok_in.pick;
                  launched_ff <= 1'b1;
                  rsp_ok_ff <= 1'b1;
                  rsp_idx_ff <= 3'(tok_in.pick);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_task_index = rsp_idx_ff;
endmodule

// File: design/pts_cell.sv
// One task slot of the scheduler table: priority, flags and sleep timer.
// Depends on pts_pkg.
module pts_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [pts_pkg::IdxW-1:0] cell_idx,
   input  pts_pkg::cell_cmd_type cmd,
   output pts_pkg::cell_stat_type stat
);
   import pts_pkg::*;

   logic [7:0]  prio_ff;
   logic [31:0] len_ff, start_ff;
   logic        susp_ff, blk_ff, slp_ff;
   logic        hit, expired;

   assign hit = (cmd.wr_idx == cell_idx);
   assign expired = slp_ff && !susp_ff && ((cmd.tick - start_ff) >= len_ff);

   // Control flags of the slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         susp_ff <= 1'b0;
         blk_ff  <= 1'b0;
         slp_ff  <= 1'b0;
      end else if (hit && cmd.create) begin
         susp_ff <= 1'b0;
         blk_ff  <= 1'b0;
         slp_ff  <= 1'b0;
      end else if (hit && cmd.sleep) begin
         blk_ff <= 1'b1;
         slp_ff <= 1'b1;
      end else if (hit && cmd.suspend) begin
         susp_ff <= 1'b1;
      end else if (hit && cmd.resume) begin
         susp_ff <= 1'b0;
      end else if (cmd.wake && expired) begin
         blk_ff <= 1'b0;
         slp_ff <= 1'b0;
      end
   end

   // Payload of the slot.
   always_ff @(posedge clock) begin
      if (hit && (cmd.create || cmd.setprio)) begin
         prio_ff <= cmd.prio;
      end
      if (hit && cmd.sleep) begin
         len_ff   <= cmd.duration;
         start_ff <= cmd.tick;
      end
   end

   assign stat.suspended = susp_ff;
   assign stat.ready = !susp_ff && !blk_ff;
   assign stat.prio = prio_ff;
endmodule

// File: design/pts_scan.sv
// One stage of the ring search: compares a slot against the running best.
// Depends on pts_pkg.
module pts_scan (
   input  logic                   launch,
   input  logic                   active,
   input  logic [pts_pkg::IdxW-1:0] idx,
   input  pts_pkg::cell_stat_type stat,
   input  pts_pkg::token_type     tok_in,
   output pts_pkg::token_type     tok_out
);
   import pts_pkg::*;

   logic take;

   // Launch ignores flags; a normal pick needs a ready task.
   assign take = active && ({1'b0, stat.prio} < tok_in.best) && (launch || stat.ready);

   always_comb begin
      tok_out = tok_in;
      if (take) begin
         tok_out.best = {1'b0, stat.prio};
         tok_out.pick = idx;
      end
   end
endmodule

// File: design/pts_checker.sv
// Port-level checker for the priority task scheduler, bound to the top level.
// Depends on priority_task_scheduler.
module pts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_ok,
   input logic [2:0] rsp_task_index
);
   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_task_index))
      else $error("response changed while stalled");

   // No new request is taken while a response is stalled.
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken under stall");

   // No second request is taken while the first is in work.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && !rsp_ready) |=> !req_ready)
      else $error("second request taken while first in work");

   // Reset leaves the response channel empty.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
   .rsp_task_index(rsp_task_index)
);

// File: tb/tb.sv
// Self-checking testbench for the priority task scheduler top level.
// Depends on pts_pkg and priority_task_scheduler; drives requests, predicts each
// response with a behavioral model of the task table and compares in order.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pts_pkg::*;

   localparam int NumSlots = 8;
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   action_type req_action = ACT_TICK;
   logic [2:0] req_task_id = '0;
   logic [7:0] req_prio_value = '0;
   logic [31:0] req_duration = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_ok;
   logic [2:0] rsp_task_index;

   typedef struct {
      logic ok;
      logic [2:0] index;
   } answer_type;

   // Behavioral copy of the scheduler state.
   logic [7:0] model_prio [NumSlots];
   logic model_susp [NumSlots];
   logic model_blocked [NumSlots];
   logic model_asleep [NumSlots];
   logic [31:0] model_sleep_len [NumSlots];
   logic [31:0] model_sleep_from [NumSlots];
   int unsigned model_count;
   int unsigned model_current;
   logic model_launched;
   logic [31:0] model_ticks;

   answer_type pending_answers [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned answers_checked = 0;
   int unsigned cycle_count = 0;
   int unsigned sent_count = 0;
   int unsigned action_hits [8];

   priority_task_scheduler DUT (.*);

   always #5 clock = ~clock;

   // Wake every sleeper whose elapsed ticks reached its length.
   function automatic void wake_expired_sleepers();
      for (int i = 0; i < model_count; i++)
         if (model_asleep[i] && !model_susp[i] &&
               (model_ticks - model_sleep_from[i]) >= model_sleep_len[i]) begin
            model_asleep[i] = 1'b0;
            model_blocked[i] = 1'b0;
         end
   endfunction

   // Ring search from the slot after the current one, strict lowest wins.
   function automatic void choose_next_task();
      int unsigned best;
      int unsigned pick;
      int unsigned slot;
      best = 256;
      pick = model_current;
      for (int k = 1; k <= model_count; k++) begin
         slot = (model_current + k) % model_count;
         if (model_prio[slot] < best && !model_susp[slot] && !model_blocked[slot]) begin
            best = model_prio[slot];
            pick = slot;
         end
      end
      model_current = pick;
   endfunction

   // Apply one request to the model and return the expected response.
   function automatic answer_type predict_answer(action_type act, logic [2:0] tid,
                                                 logic [7:0] prio, logic [31:0] dur);
      answer_type a;
      int unsigned best;
      a.ok = 1'b0;
      a.index = model_current[2:0];
      case (act)
         ACT_TICK: begin
            model_ticks = model_ticks + 32'd1;
            a.ok = 1'b1;
         end
         ACT_SCHED: begin
            if (model_count != 0) begin
               if (!model_launched) begin
                  best = model_prio[0];
                  model_current = 0;
                  for (int i = 0; i < model_count; i++)
                     if (model_prio[i] < best) begin
                        best = model_prio[i];
                        model_current = i;
                     end
                  model_launched = 1'b1;
               end else begin
                  wake_expired_sleepers();
                  choose_next_task();
               end
               a.ok = 1'b1;
            end
         end
         ACT_CREATE: begin
            if (model_count < NumSlots && !(prio == PrioReserved && model_count > 0)) begin
               model_prio[model_count] = prio;
               model_susp[model_count] = 1'b0;
               model_blocked[model_count] = 1'b0;
               model_asleep[model_count] = 1'b0;
               model_sleep_len[model_count] = '0;
               model_sleep_from[model_count] = '0;
               model_count++;
               a.ok = 1'b1;
            end
         end
         ACT_SLEEP: begin
            if (model_launched && model_count != 0) begin
               if (dur != 0) begin
                  model_sleep_len[model_current] = dur;
                  model_sleep_from[model_current] = model_ticks;
                  model_asleep[model_current] = 1'b1;
                  model_blocked[model_current] = 1'b1;
               end
               wake_expired_sleepers();
               choose_next_task();
               a.ok = 1'b1;
            end
         end
         ACT_SUSPEND: begin
            if (tid < model_count && !model_susp[tid]) begin
               model_susp[tid] = 1'b1;
               a.ok = 1'b1;
            end
         end
         ACT_RESUME: begin
            if (tid < model_count && model_susp[tid]) begin
               model_susp[tid] = 1'b0;
               a.ok = 1'b1;
            end
         end
         ACT_SETPRIO: begin
            if (tid < model_count) begin
               model_prio[tid] = prio;
               a.ok = 1'b1;
            end
         end
         default: ;
      endcase
      if (act == ACT_CREATE)
         a.index = a.ok ? 3'(model_count - 1) : 3'd0;
      else
         a.index = model_current[2:0];
      return a;
   endfunction

   // Send one request transaction and queue its expected response.
   // Valid drops only when the sender idles, so back-to-back requests keep it high.
   task automatic send_request(action_type act, logic [2:0] tid, logic [7:0] prio,
                               logic [31:0] dur);
      if ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_task_id <= tid;
      req_prio_value <= prio;
      req_duration <= dur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_answers.push_back(predict_answer(act, tid, prio, dur));
      action_hits[act]++;
      sent_count++;
   endtask

   // Wait until every response is in, so the next phase starts from idle.
   task automatic drain_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [31:0] random_duration();
      case ($urandom_range(3, 0))
         0: return 32'($urandom_range(3, 0));
         1: return 32'($urandom_range(20, 1));
         2: return 32'hFFFF_FFFF - 32'($urandom_range(2, 0));
         default: return $urandom();
      endcase
   endfunction

   // Receiver: random stalls and in-order comparison.
   always @(posedge clock) begin
      answer_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response ok=%0b index=%0d", rsp_ok, rsp_task_index);
            end else begin
               want = pending_answers.pop_front();
               answers_checked++;
               if (rsp_ok !== want.ok || rsp_task_index !== want.index) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response mismatch: expected ok=%0b index=%0d, got ok=%0b index=%0d",
                              want.ok, want.index, rsp_ok, rsp_task_index);
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Edge values on an empty table, then fill it, run launch and exercise suspend, sleep, tick and resume.
   task automatic test_directed_basics();
      send_request(ACT_SCHED, 3'd0, 8'd0, 32'd0);
      send_request(ACT_SLEEP, 3'd0, 8'd0, 32'd5);
      send_request(ACT_SUSPEND, 3'd0, 8'd0, 32'd0);
      send_request(ACT_NONE, 3'd7, 8'hFF, 32'hFFFF_FFFF);
      send_request(ACT_CREATE, 3'd0, 8'd255, 32'd0);
      send_request(ACT_CREATE, 3'd0, 8'd255, 32'd0);
      send_request(ACT_CREATE, 3'd0, 8'd0, 32'd0);
      for (int i = 0; i < 7; i++)
         send_request(ACT_CREATE, 3'd0, 8'(i % 3 + 1), 32'd0);
      send_request(ACT_SETPRIO, 3'd7, 8'd3, 32'd0);
      send_request(ACT_SCHED, 3'd0, 8'd0, 32'd0);
      send_request(ACT_SUSPEND, 3'd1, 8'd0, 32'd0);
      send_request(ACT_SUSPEND, 3'd1, 8'd0, 32'd0);
      send_request(ACT_SLEEP, 3'd0, 8'd0, 32'd0);
      send_request(ACT_SLEEP, 3'd0, 8'd0, 32'd2);
      send_request(ACT_TICK, 3'd0, 8'd0, 32'd0);
      send_request(ACT_TICK, 3'd0, 8'd0, 32'd0);
      send_request(ACT_RESUME, 3'd1, 8'd0, 32'd0);
      send_request(ACT_RESUME, 3'd2, 8'd0, 32'd0);
      send_request(ACT_SCHED, 3'd0, 8'd0, 32'd0);
      send_request(ACT_SLEEP, 3'd0, 8'd0, 32'hFFFF_FFFF);
   endtask

   // Random traffic: a random mix of all actions exercises scheduling on the table.
   task automatic test_random_traffic(int unsigned items);
      int unsigned done;
      int unsigned pick;
      action_type act;
      done = 0;
      while (done < items) begin
         pick = $urandom_range(99, 0);
         if (pick < 20) act = ACT_TICK;
         else if (pick < 40) act = ACT_SCHED;
         else if (pick < 50) act = ACT_CREATE;
         else if (pick < 65) act = ACT_SLEEP;
         else if (pick < 75) act = ACT_SUSPEND;
         else if (pick < 87) act = ACT_RESUME;
         else if (pick < 98) act = ACT_SETPRIO;
         else act = ACT_NONE;
         send_request(act, 3'($urandom_range(7, 0)),
                      ($urandom_range(9, 0) == 0) ? 8'($urandom()) : 8'($urandom_range(4, 0)),
                      random_duration());
         done++;
      end
   endtask

   // Many ticks in a row so that short sleeps expire, then a schedule.
   task automatic test_tick_bursts();
      for (int i = 0; i < 40; i++)
         send_request(ACT_TICK, 3'd0, 8'd0, 32'd0);
      send_request(ACT_SCHED, 3'd0, 8'd0, 32'd0);
   endtask

   initial begin
      for (int i = 0; i < NumSlots; i++) begin
         model_prio[i] = '0;
         model_susp[i] = 1'b0;
         model_blocked[i] = 1'b0;
         model_asleep[i] = 1'b0;
         model_sleep_len[i] = '0;
         model_sleep_from[i] = '0;
      end
      model_count = 0;
      model_current = 0;
      model_launched = 1'b0;
      model_ticks = '0;
      for (int i = 0; i < 8; i++) action_hits[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 72;
      test_directed_basics();
      test_random_traffic(350);
      send_idle_pct = 72;
      recv_idle_pct = 33;
      test_tick_bursts();
      test_random_traffic(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(350);
      drain_answers();

      $display("sent %0d requests, checked %0d responses, %0d tasks created",
               sent_count, answers_checked, model_count);
      $display("per action: tick %0d sched %0d create %0d sleep %0d susp %0d res %0d prio %0d",
               action_hits[0], action_hits[1], action_hits[2], action_hits[3],
               action_hits[4], action_hits[5], action_hits[6]);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
